>>> design/stbs_pkg.sv
// shared types and constants for the sorted table binary search block
package stbs_pkg;

  localparam int IDX_W = 10;          // width of every index field
  localparam int VAL_W = 64;          // q32.32 value width
  localparam int PTR_W = IDX_W + 2;   // signed range bound, holds -1 and one past the top

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [PTR_W-1:0] ptr_t;

endpackage

>>> design/stbs_if.sv
// beat channels of the sorted table binary search block

interface stbs_in_if;
  logic          valid;
  logic          ready;
  logic          func;
  stbs_pkg::idx_t entry_index;
  stbs_pkg::val_t entry_value;
  stbs_pkg::idx_t search_low;
  stbs_pkg::idx_t search_high;
  stbs_pkg::val_t search_key;

  modport source (output valid, func, entry_index, entry_value, search_low, search_high,
                  search_key, input ready);
  modport sink (input valid, func, entry_index, entry_value, search_low, search_high,
                search_key, output ready);
endinterface

interface stbs_out_if;
  logic          valid;
  logic          ready;
  logic          found;
  stbs_pkg::idx_t position;

  modport source (output valid, found, position, input ready);
  modport sink (input valid, found, position, output ready);
endinterface

>>> design/stbs_table.sv
// table memory: one write port, one read port with registered read data
module stbs_table #(
  parameter int TABLE_DEPTH = 1024,
  parameter int AW          = 10
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  stbs_pkg::val_t wr_data,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output stbs_pkg::val_t rd_data
);

  stbs_pkg::val_t mem [TABLE_DEPTH];
  stbs_pkg::val_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/sorted_table_binary_search.sv
// sorted table binary search: write items fill the table, search items halve a range
// write beat: accepted in idle, stored the same cycle, no result; state stays idle
// search beat: each probe reads the table in S_CHECK, then compares in S_CMP;
//   S_CHECK closes an empty range; S_RES loads the output register once it is free
// the probe loop over the single-read-port table sets the rate; one item at a time
// reset clears the control state and the output valid; table contents stay undefined
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic clk,
  input  logic rst_n,
  stbs_in_if.sink    in_ch,
  stbs_out_if.source out_ch
);

  // table address width, at least one bit
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // take a beat
  localparam logic [2:0] S_CHECK = 3'd1;  // test the range, issue the probe read
  localparam logic [2:0] S_CMP   = 3'd2;  // read data back, compare with the key
  localparam logic [2:0] S_RES   = 3'd3;  // move the answer into the output register

  logic [2:0]     state_r, state_nxt;
  stbs_pkg::ptr_t lo_r, lo_nxt;
  stbs_pkg::ptr_t hi_r, hi_nxt;
  stbs_pkg::idx_t mid_r, mid_nxt;
  stbs_pkg::val_t key_r, key_nxt;
  logic           res_found_r, res_found_nxt;
  stbs_pkg::idx_t res_pos_r, res_pos_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_found_r, out_found_nxt;
  stbs_pkg::idx_t out_position_r, out_position_nxt;

  logic           in_fire;
  logic           slot_free;
  logic           wr_en;
  logic           rd_en;
  stbs_pkg::val_t rd_data;
  stbs_pkg::ptr_t mid_sum;
  stbs_pkg::idx_t mid_c;
  stbs_pkg::idx_t hi_sat;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  // writes past the end of the table are dropped
  assign wr_en = in_fire && (in_ch.func == stbs_pkg::FUNC_WRITE) &&
                 (32'(in_ch.entry_index) < 32'(TABLE_DEPTH));

  // the top of the range is clipped to the last table entry
  assign hi_sat = (32'(in_ch.search_high) > 32'(TABLE_DEPTH - 1)) ?
                  stbs_pkg::idx_t'(TABLE_DEPTH - 1) : in_ch.search_high;

  // midpoint; both bounds are non-negative whenever a probe is issued
  assign mid_sum = lo_r + hi_r;
  assign mid_c   = mid_sum[stbs_pkg::IDX_W:1];
  assign rd_en   = (state_r == S_CHECK) && (lo_r <= hi_r);

  stbs_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_ch.entry_index)),
    .wr_data (in_ch.entry_value),
    .rd_en   (rd_en),
    .rd_addr (AW'(mid_c)),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt        = state_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    mid_nxt          = mid_r;
    key_nxt          = key_r;
    res_found_nxt    = res_found_r;
    res_pos_nxt      = res_pos_r;
    out_valid_nxt    = out_valid_r;
    out_found_nxt    = out_found_r;
    out_position_nxt = out_position_r;

    // output beat leaves
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_ch.func == stbs_pkg::FUNC_SEARCH)) begin
          lo_nxt    = stbs_pkg::ptr_t'(in_ch.search_low);
          hi_nxt    = stbs_pkg::ptr_t'(hi_sat);
          key_nxt   = in_ch.search_key;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (lo_r <= hi_r) begin
          mid_nxt   = mid_c;
          state_nxt = S_CMP;
        end else begin
          // range closed without a match
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          state_nxt     = S_RES;
        end
      end
      S_CMP: begin
        if (key_r < rd_data) begin
          hi_nxt    = stbs_pkg::ptr_t'(mid_r) - stbs_pkg::ptr_t'(1);
          state_nxt = S_CHECK;
        end else if (key_r > rd_data) begin
          lo_nxt    = stbs_pkg::ptr_t'(mid_r) + stbs_pkg::ptr_t'(1);
          state_nxt = S_CHECK;
        end else begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = mid_r;
          state_nxt     = S_RES;
        end
      end
      S_RES: begin
        // wait for the output register to drain
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_found_nxt    = res_found_r;
          out_position_nxt = res_pos_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    lo_r           <= lo_nxt;
    hi_r           <= hi_nxt;
    mid_r          <= mid_nxt;
    key_r          <= key_nxt;
    res_found_r    <= res_found_nxt;
    res_pos_r      <= res_pos_nxt;
    out_found_r    <= out_found_nxt;
    out_position_r <= out_position_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.position = out_position_r;

  // a compare always follows its probe read
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ($past(state_r) == S_CHECK))
    else $error("compare without a probe read");

  // the probed index lies inside the live range
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ((stbs_pkg::ptr_t'(mid_r) >= lo_r) &&
                            (stbs_pkg::ptr_t'(mid_r) <= hi_r)))
    else $error("probe outside the search range");

  // every probe that misses shrinks the range
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP && key_r != rd_data) |=>
      ((hi_r - lo_r) < $past(hi_r - lo_r)))
    else $error("search range did not shrink");

  // a miss always reports position zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_position_r == '0))
    else $error("not-found result with nonzero position");

  // a hit reports an index inside the table
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (32'(out_position_r) < 32'(TABLE_DEPTH)))
    else $error("hit position beyond the table");

endmodule
